// ----- rtl/shell_vertex_normal_offset_core_assert.svh -----
// assertion macros for the shell vertex offset core
// expects clk and rst_n in the scope that uses them
`ifndef SHELL_VERTEX_NORMAL_OFFSET_CORE_ASSERT_SVH
`define SHELL_VERTEX_NORMAL_OFFSET_CORE_ASSERT_SVH

// same-cycle implication
`define SVNO_CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shell offset check failed");

// delayed implication, the delay given by dly
`define SVNO_CHK_LATER(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("shell offset latency check failed");

`endif

// ----- rtl/svno_pkg.sv -----
// types, widths and helpers for the shell vertex offset core
// no dependencies
package svno_pkg;

  localparam int CW       = 32;
  localparam int MAG_BITS = ((63 - CW) < 30) ? (63 - CW) : 30;
  localparam int EW       = CW + 1;
  localparam int PW       = 2 * EW;
  localparam int XW       = PW + 1;
  localparam int MW       = XW - 1;
  localparam int TH_W     = CW - 1;
  localparam int ROOT_W   = MAG_BITS + 1;
  localparam int SQ_W     = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 2;
  localparam int NUM_W    = MAG_BITS + TH_W + 1;
  localparam int DIV_W    = ROOT_W + 1;
  localparam int Q_W      = TH_W;
  localparam int GRP      = 8;
  localparam int NGRP     = (MW + GRP - 1) / GRP;
  localparam int GPOS_W   = $clog2(GRP);
  localparam int SH_W     = $clog2(NGRP * GRP + 1);

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic signed [CW-1:0] first_nbr_x;
    logic signed [CW-1:0] first_nbr_y;
    logic signed [CW-1:0] first_nbr_z;
    logic signed [CW-1:0] second_nbr_x;
    logic signed [CW-1:0] second_nbr_y;
    logic signed [CW-1:0] second_nbr_z;
    logic                 inverted;
  } in_beat_t;

  typedef struct packed {
    logic signed [CW-1:0] top_x;
    logic signed [CW-1:0] top_y;
    logic signed [CW-1:0] top_z;
    logic signed [CW-1:0] bottom_x;
    logic signed [CW-1:0] bottom_y;
    logic signed [CW-1:0] bottom_z;
    logic                 degenerate;
  } out_beat_t;

  // per-item sideband that rides along the pipe
  typedef struct packed {
    logic [2:0][CW-1:0] c;
    logic               inv;
    logic [2:0]         sg;
    logic               degen;
  } carry_t;

  // clamp to the signed coordinate range
  function automatic logic [CW-1:0] sat_coord(input logic [CW+1:0] v);
    logic [CW-1:0] r;
    if (!v[CW+1] && (v[CW:CW-1] != 2'b00)) begin
      r = {1'b0, {(CW-1){1'b1}}};
    end else if (v[CW+1] && (v[CW:CW-1] != 2'b11)) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/shell_vertex_normal_offset_core.sv -----
// shell vertex offset core: cross product normal, sqrt, divide, offset
// depends on svno_pkg and shell_vertex_normal_offset_core_assert.svh
//
// usage
// - input: pulse start with in_data (vertex, two grid neighbors, inverted flag);
//   a beat is taken at every edge where start is high, busy is always low
// - output: out_strobe is high for one cycle with out_data; the receiver
//   cannot stall, so results leave the pipe as they arrive
// - config: cfg_we with cfg_wdata loads the full shell thickness (Q15.16);
//   write it only while no beat is in flight
// - stages: 9 front-end stages, 31 square-root stages, one multiply stage,
//   31 divide stages, one output stage
// - throughput: one beat per cycle; every stage is a plain register stage,
//   the root and quotient take one bit per stage
// - reset: clears the valid chain and the thickness; in-flight beats are dropped
module shell_vertex_normal_offset_core
  import svno_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  in_beat_t      in_data,
  output logic          out_strobe,
  output out_beat_t     out_data,
  input  logic          cfg_we,
  input  logic [TH_W-1:0] cfg_wdata
);

  // stage indexes
  localparam int ST_MAG = 4;
  localparam int ST_M   = 7;
  localparam int ST_SQ0 = 9;
  localparam int ST_NUM = ST_SQ0 + ROOT_W + 1;
  localparam int DEPTH  = ST_NUM + Q_W + 1;

  logic [TH_W-1:0] thick_r;
  logic            vld_r [1:DEPTH];
  carry_t          car_r [1:DEPTH-1];

  // never back-pressures
  assign busy = 1'b0;

  // thickness register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thick_r <= '0;
    end else if (cfg_we) begin
      thick_r <= cfg_wdata;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= DEPTH; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[1] <= start && !busy;
      for (int k = 2; k <= DEPTH; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // stage 1: edge vectors
  logic [2:0][CW-1:0] c_in, n1_in, n2_in;
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];

  assign c_in  = {in_data.center_z, in_data.center_y, in_data.center_x};
  assign n1_in = {in_data.first_nbr_z, in_data.first_nbr_y, in_data.first_nbr_x};
  assign n2_in = {in_data.second_nbr_z, in_data.second_nbr_y, in_data.second_nbr_x};

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      e1_r[k] <= {n1_in[k][CW-1], n1_in[k]} - {c_in[k][CW-1], c_in[k]};
      e2_r[k] <= {n2_in[k][CW-1], n2_in[k]} - {c_in[k][CW-1], c_in[k]};
    end
    car_r[1].c     <= c_in;
    car_r[1].inv   <= in_data.inverted;
    car_r[1].sg    <= '0;
    car_r[1].degen <= 1'b0;
  end

  // stage 2: six partial products of the cross product
  logic signed [PW-1:0] p_r [6];
  always_ff @(posedge clk) begin
    p_r[0] <= e1_r[1] * e2_r[2];
    p_r[1] <= e1_r[2] * e2_r[1];
    p_r[2] <= e1_r[2] * e2_r[0];
    p_r[3] <= e1_r[0] * e2_r[2];
    p_r[4] <= e1_r[0] * e2_r[1];
    p_r[5] <= e1_r[1] * e2_r[0];
  end

  // stage 3: cross components
  logic [XW-1:0] cr_r [3];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      cr_r[k] <= {p_r[2*k][PW-1], p_r[2*k]} - {p_r[2*k+1][PW-1], p_r[2*k+1]};
    end
  end

  // stage 4: sign and magnitude
  logic [MW-1:0] mag4_r [3];
  logic [2:0]    cr_sg;
  logic          cr_zero;
  logic [XW-1:0] cr_abs [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cr_sg[k]  = cr_r[k][XW-1];
      cr_abs[k] = cr_sg[k] ? (~cr_r[k] + XW'(1)) : cr_r[k];
    end
    cr_zero = (cr_r[0] == '0) && (cr_r[1] == '0) && (cr_r[2] == '0);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) mag4_r[k] <= cr_abs[k][MW-1:0];
  end

  // stage 5: per-group leading one over the or of the magnitudes
  logic [NGRP*GRP-1:0] or_w;
  logic [NGRP-1:0]     gnz;
  logic [GPOS_W-1:0]   gpos [NGRP];
  logic [NGRP-1:0]     gnz_r;
  logic [GPOS_W-1:0]   gpos_r [NGRP];
  logic [MW-1:0]       mag5_r [3];

  always_comb begin
    or_w = (NGRP*GRP)'(mag4_r[0] | mag4_r[1] | mag4_r[2]);
    for (int g = 0; g < NGRP; g++) begin
      gnz[g]  = |or_w[g*GRP +: GRP];
      gpos[g] = '0;
      for (int b = 0; b < GRP; b++) begin
        if (or_w[g*GRP + b]) gpos[g] = GPOS_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    gnz_r  <= gnz;
    gpos_r <= gpos;
    mag5_r <= mag4_r;
  end

  // stage 6: common right shift
  logic [SH_W-1:0] bl;
  logic [SH_W-1:0] sh_r;
  logic [MW-1:0]   mag6_r [3];

  always_comb begin
    bl = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (gnz_r[g]) bl = SH_W'(g*GRP) + SH_W'(gpos_r[g]) + SH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= (bl > SH_W'(MAG_BITS)) ? (bl - SH_W'(MAG_BITS)) : '0;
    mag6_r <= mag5_r;
  end

  // stage 7: normalized magnitudes, carried to the multiply stage
  logic [2:0][MAG_BITS-1:0] m_r [ST_M:ST_NUM-1];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) m_r[ST_M][k] <= MAG_BITS'(mag6_r[k] >> sh_r);
  end

  // stage 8: squares
  logic [2*MAG_BITS-1:0] sqr_r [3];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) sqr_r[k] <= m_r[ST_M][k] * m_r[ST_M][k];
  end

  // stage 9 and on: square root, two radicand bits per stage
  logic [SQ_W-1:0]   sq_v_r    [0:ROOT_W];
  logic [REM_W-1:0]  sq_rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0] sq_root_r [0:ROOT_W];

  always_ff @(posedge clk) begin
    sq_v_r[0]    <= SQ_W'(sqr_r[0]) + SQ_W'(sqr_r[1]) + SQ_W'(sqr_r[2]);
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
  end

  for (genvar j = 1; j <= ROOT_W; j++) begin : g_sqrt
    logic [REM_W+1:0] rem4;
    logic [REM_W+1:0] trial;
    assign rem4  = {sq_rem_r[j-1], sq_v_r[j-1][SQ_W-2*j+1 -: 2]};
    assign trial = (REM_W+2)'({sq_root_r[j-1], 2'b01});
    always_ff @(posedge clk) begin
      sq_v_r[j] <= sq_v_r[j-1];
      if (rem4 >= trial) begin
        sq_rem_r[j]  <= REM_W'(rem4 - trial);
        sq_root_r[j] <= {sq_root_r[j-1][ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_r[j]  <= REM_W'(rem4);
        sq_root_r[j] <= {sq_root_r[j-1][ROOT_W-2:0], 1'b0};
      end
    end
  end

  for (genvar k = ST_M + 1; k < ST_NUM; k++) begin : g_mpipe
    always_ff @(posedge clk) m_r[k] <= m_r[k-1];
  end

  // multiply stage and long division, one quotient bit per stage
  logic [2:0][NUM_W-1:0] dv_num_r [0:Q_W];
  logic [2:0][DIV_W-1:0] dv_rem_r [0:Q_W];
  logic [2:0][Q_W-1:0]   dv_q_r   [0:Q_W];
  logic [DIV_W-1:0]      dv_d_r   [0:Q_W];
  logic [2:0][NUM_W-1:0] num_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_c[k] = NUM_W'(m_r[ST_NUM-1][k] * thick_r) + NUM_W'(sq_root_r[ROOT_W]);
    end
  end

  always_ff @(posedge clk) begin
    dv_num_r[0] <= num_c;
    dv_d_r[0]   <= {sq_root_r[ROOT_W], 1'b0};
    for (int k = 0; k < 3; k++) begin
      dv_rem_r[0][k] <= DIV_W'(num_c[k][NUM_W-1:Q_W]);
      dv_q_r[0][k]   <= '0;
    end
  end

  for (genvar i = 1; i <= Q_W; i++) begin : g_div
    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [DIV_W:0] r2;
      assign r2 = {dv_rem_r[i-1][k], dv_num_r[i-1][k][Q_W-i]};
      always_ff @(posedge clk) begin
        if (r2 >= {1'b0, dv_d_r[i-1]}) begin
          dv_rem_r[i][k] <= DIV_W'(r2 - {1'b0, dv_d_r[i-1]});
          dv_q_r[i][k]   <= {dv_q_r[i-1][k][Q_W-2:0], 1'b1};
        end else begin
          dv_rem_r[i][k] <= DIV_W'(r2);
          dv_q_r[i][k]   <= {dv_q_r[i-1][k][Q_W-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      dv_num_r[i] <= dv_num_r[i-1];
      dv_d_r[i]   <= dv_d_r[i-1];
    end
  end

  // sideband copy, sign and zero flags join at the magnitude stage
  for (genvar k = 2; k < DEPTH; k++) begin : g_carry
    if (k == ST_MAG) begin : g_mag
      always_ff @(posedge clk) begin
        car_r[k].c     <= car_r[k-1].c;
        car_r[k].inv   <= car_r[k-1].inv;
        car_r[k].sg    <= cr_sg;
        car_r[k].degen <= cr_zero;
      end
    end else begin : g_cp
      always_ff @(posedge clk) car_r[k] <= car_r[k-1];
    end
  end

  // output stage: signed offset and saturating add and subtract
  carry_t             fin;
  logic [2:0][CW+1:0] off, top_s, bot_s;
  out_beat_t          out_r;
  logic               out_neg;
  logic               out_flat;

  always_comb begin
    fin = car_r[DEPTH-1];
    for (int k = 0; k < 3; k++) begin
      out_neg = fin.sg[k] ^ ~fin.inv;
      off[k]  = fin.degen ? '0 : (CW+2)'(dv_q_r[Q_W][k]);
      if (out_neg) off[k] = ~off[k] + (CW+2)'(1);
      top_s[k] = {{2{fin.c[k][CW-1]}}, fin.c[k]} + off[k];
      bot_s[k] = {{2{fin.c[k][CW-1]}}, fin.c[k]} - off[k];
    end
  end

  always_ff @(posedge clk) begin
    out_r.top_x      <= sat_coord(top_s[0]);
    out_r.top_y      <= sat_coord(top_s[1]);
    out_r.top_z      <= sat_coord(top_s[2]);
    out_r.bottom_x   <= sat_coord(bot_s[0]);
    out_r.bottom_y   <= sat_coord(bot_s[1]);
    out_r.bottom_z   <= sat_coord(bot_s[2]);
    out_r.degenerate <= fin.degen;
  end

  assign out_data   = out_r;
  assign out_strobe = vld_r[DEPTH];

  // both points coincide
  assign out_flat = (out_data.top_x == out_data.bottom_x) &&
                    (out_data.top_y == out_data.bottom_y) &&
                    (out_data.top_z == out_data.bottom_z);

`include "shell_vertex_normal_offset_core_assert.svh"

  `SVNO_CHK_LATER(a_latency, start && !busy, DEPTH, out_strobe)
  `SVNO_CHK_NOW(a_degen_flat, out_strobe && out_data.degenerate, out_flat)
  `SVNO_CHK_NOW(a_len_nz, vld_r[ST_NUM-1] && !car_r[ST_NUM-1].degen, sq_root_r[ROOT_W] != '0)

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// testbench for shell_vertex_normal_offset_core: directed and random vertex beats,
// a cross-product/normalize/offset predictor in a scoreboard class; depends on svno_pkg

module tb_top
  import svno_pkg::*;
;

class shell_offset_scoreboard;
  out_beat_t    pending_q[$];
  logic [63:0]  thick;
  int           mismatches;
  int           strays;

  function new();
    thick      = 0;
    mismatches = 0;
    strays     = 0;
  endfunction

  // floor of the square root, bit by bit
  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] clamp_coord(logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  // offset the vertex both ways along the unit normal of the two grid edges
  function automatic out_beat_t offset_points(in_beat_t b);
    logic signed [127:0] c[3];
    logic signed [127:0] e1[3];
    logic signed [127:0] e2[3];
    logic signed [127:0] cr[3];
    logic [127:0]        mg[3];
    logic [127:0]        orv;
    logic                sg[3];
    logic [63:0]         m[3];
    logic [63:0]         sq;
    logic [63:0]         len;
    logic [63:0]         q;
    logic signed [127:0] off[3];
    logic [CW-1:0]       top[3];
    logic [CW-1:0]       bot[3];
    logic                degen;
    int                  bl;
    int                  s;
    out_beat_t           r;
    c[0]  = b.center_x;     c[1]  = b.center_y;     c[2]  = b.center_z;
    e1[0] = b.first_nbr_x;  e1[1] = b.first_nbr_y;  e1[2] = b.first_nbr_z;
    e2[0] = b.second_nbr_x; e2[1] = b.second_nbr_y; e2[2] = b.second_nbr_z;
    for (int k = 0; k < 3; k++) begin
      e1[k] = e1[k] - c[k];
      e2[k] = e2[k] - c[k];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    orv = 0;
    for (int k = 0; k < 3; k++) begin
      sg[k] = cr[k] < 0;
      mg[k] = sg[k] ? -cr[k] : cr[k];
      orv   = orv | mg[k];
    end
    degen = (orv == 0);
    bl = 0;
    for (int i = 0; i < 128; i++) if (orv[i]) bl = i + 1;
    s = (bl > MAG_BITS) ? bl - MAG_BITS : 0;
    sq = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = 64'(mg[k] >> s);
      sq   = sq + m[k] * m[k];
    end
    len = floor_root(sq);
    for (int k = 0; k < 3; k++) begin
      off[k] = 0;
      if (!degen && len != 0) begin
        q = (m[k] * thick + len) / (2 * len);
        off[k] = (sg[k] != !b.inverted) ? -$signed({64'd0, q}) : $signed({64'd0, q});
      end
      top[k] = clamp_coord(c[k] + off[k]);
      bot[k] = clamp_coord(c[k] - off[k]);
    end
    r.top_x = top[0];    r.top_y = top[1];    r.top_z = top[2];
    r.bottom_x = bot[0]; r.bottom_y = bot[1]; r.bottom_z = bot[2];
    r.degenerate = degen;
    return r;
  endfunction

  function void note_input(in_beat_t b);
    pending_q = {pending_q, offset_points(b)};
  endfunction

  function void check_result(out_beat_t got);
    out_beat_t exp_r;
    if (pending_q.size() == 0) begin
      strays++;
      if (strays + mismatches <= 10) $display("unexpected result beat %h", got);
      return;
    end
    exp_r = pending_q.pop_front();
    if (got.top_x !== exp_r.top_x || got.top_y !== exp_r.top_y ||
        got.top_z !== exp_r.top_z || got.bottom_x !== exp_r.bottom_x ||
        got.bottom_y !== exp_r.bottom_y || got.bottom_z !== exp_r.bottom_z ||
        got.degenerate !== exp_r.degenerate) begin
      mismatches++;
      if (strays + mismatches <= 10) begin
        $display("mismatch top exp %h %h %h got %h %h %h", exp_r.top_x, exp_r.top_y,
                 exp_r.top_z, got.top_x, got.top_y, got.top_z);
        $display("  bottom exp %h %h %h got %h %h %h", exp_r.bottom_x, exp_r.bottom_y,
                 exp_r.bottom_z, got.bottom_x, got.bottom_y, got.bottom_z);
        $display("  degenerate exp %b got %b", exp_r.degenerate, got.degenerate);
      end
    end
  endfunction
endclass

  localparam int DRAIN_CYCLES = 90;
  localparam int STALL_LIMIT  = 3000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  in_beat_t      in_data = '0;
  logic          out_strobe;
  out_beat_t     out_data;
  logic          cfg_we = 1'b0;
  logic [TH_W-1:0] cfg_wdata = '0;

  shell_offset_scoreboard sb = new();
  int idle_pct = 12;
  int quiet_cycles = 0;
  bit timed_out = 1'b0;

  shell_vertex_normal_offset_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sample accepted beats on the edge; results cannot be held off
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_input(in_data);
      if (out_strobe) sb.check_result(out_data);
      if ((start && !busy) || out_strobe) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // watchdog on a stalled run
  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one vertex beat, holding start high across back-to-back beats
  task automatic send_vertex(in_beat_t b);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? 1 : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // only written once the pipe is empty
  task automatic load_thickness(logic [TH_W-1:0] v);
    drain_pipe();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.thick = v;
  endtask

  function automatic in_beat_t make_vertex(logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
      logic signed [CW-1:0] cz, logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
      logic signed [CW-1:0] az, logic signed [CW-1:0] bx, logic signed [CW-1:0] by,
      logic signed [CW-1:0] bz, logic inv);
    in_beat_t b;
    b.center_x = cx;     b.center_y = cy;     b.center_z = cz;
    b.first_nbr_x = ax;  b.first_nbr_y = ay;  b.first_nbr_z = az;
    b.second_nbr_x = bx; b.second_nbr_y = by; b.second_nbr_z = bz;
    b.inverted = inv;
    return b;
  endfunction

  function automatic logic [CW-1:0] small_delta(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  // mostly cloth-like grids, plus full-range noise and collapsed neighbors
  function automatic in_beat_t random_vertex();
    in_beat_t b;
    int kind;
    int span;
    kind = $urandom_range(99);
    b = make_vertex($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, 1'($urandom_range(1)));
    if (kind < 55) begin
      span = ($urandom_range(3) == 0) ? 32'h0100_0000 : 32'h0002_0000;
      if ($urandom_range(1)) b.center_x = $signed(b.center_x) >>> $urandom_range(16);
      b.first_nbr_x  = b.center_x + small_delta(span);
      b.first_nbr_y  = b.center_y + small_delta(span);
      b.first_nbr_z  = b.center_z + small_delta(span);
      b.second_nbr_x = b.center_x + small_delta(span);
      b.second_nbr_y = b.center_y + small_delta(span);
      b.second_nbr_z = b.center_z + small_delta(span);
    end else if (kind < 65) begin
      // collinear or coincident neighbors give a zero normal
      b.first_nbr_x  = b.center_x + small_delta(1000);
      b.first_nbr_y  = b.center_y + small_delta(1000);
      b.first_nbr_z  = b.center_z + small_delta(1000);
      span = $urandom_range(3);
      b.second_nbr_x = b.center_x + span * (b.first_nbr_x - b.center_x);
      b.second_nbr_y = b.center_y + span * (b.first_nbr_y - b.center_y);
      b.second_nbr_z = b.center_z + span * (b.first_nbr_z - b.center_z);
    end else if (kind < 75) begin
      // extremes of the coordinate range
      b.center_x = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      b.first_nbr_y = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      b.second_nbr_z = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
    end
    return b;
  endfunction

  task automatic directed_vertices();
    localparam logic signed [CW-1:0] ONE  = 32'sh0001_0000;
    localparam logic signed [CW-1:0] PMAX = 32'sh7fff_ffff;
    localparam logic signed [CW-1:0] NMIN = 32'sh8000_0000;
    logic inv;
    for (int iv = 0; iv < 2; iv++) begin
      inv = 1'(iv);
      // unit grid square, normal along z
      send_vertex(make_vertex(0, 0, 0, ONE, 0, 0, 0, ONE, 0, inv));
      // axis normals along x and y
      send_vertex(make_vertex(0, 0, 0, 0, ONE, 0, 0, 0, ONE, inv));
      send_vertex(make_vertex(0, 0, 0, 0, 0, ONE, ONE, 0, 0, inv));
      // all points equal, zero normal
      send_vertex(make_vertex(5, -7, 9, 5, -7, 9, 5, -7, 9, inv));
      // collinear neighbors, zero normal
      send_vertex(make_vertex(0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE, inv));
      // full-range edges give the widest cross product
      send_vertex(make_vertex(NMIN, NMIN, NMIN, PMAX, NMIN, NMIN, NMIN, PMAX, NMIN, inv));
      send_vertex(make_vertex(PMAX, PMAX, PMAX, NMIN, PMAX, PMAX, PMAX, NMIN, PMAX, inv));
      // vertex at the range edge, offset saturates
      send_vertex(make_vertex(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX - ONE, PMAX - ONE,
                              PMAX, PMAX, inv));
      send_vertex(make_vertex(NMIN, NMIN, NMIN, NMIN + ONE, NMIN, NMIN, NMIN, NMIN + ONE,
                              NMIN, inv));
      // tiny cross product, rounding of the quotient
      send_vertex(make_vertex(1, 2, 3, 2, 2, 3, 1, 3, 3, inv));
      send_vertex(make_vertex(-1, -1, -1, 0, 0, -1, -1, 0, 0, inv));
    end
  endtask

  initial begin
    logic [TH_W-1:0] thick_set[6];
    thick_set[0] = '0;
    thick_set[1] = {TH_W{1'b1}};
    thick_set[2] = 31'h0001_0000;
    thick_set[3] = TH_W'($urandom);
    thick_set[4] = 31'd1;
    thick_set[5] = TH_W'($urandom_range(31'h0010_0000));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 6; ph++) begin
      // sender idles rarely, then often, then never
      idle_pct = (ph < 2) ? 12 : (ph < 4) ? 56 : 0;
      load_thickness(thick_set[ph]);
      if (ph < 2) directed_vertices();
      for (int i = 0; i < 185; i++) send_vertex(random_vertex());
    end
    drain_pipe();

    if (sb.mismatches == 0 && sb.strays == 0 && sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
